FILE: rtl/bole_pkg.sv
package bole_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 2;
  localparam int IDX_W        = 4;
  localparam int POS_W        = 4;
  localparam int CNT_W        = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND     = 2'd0,
    KIND_SEARCH     = 2'd1,
    KIND_REMOVE_AT  = 2'd2,
    KIND_REMOVE_VAL = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

endpackage

FILE: rtl/bole_if.sv
interface bole_req_if;
  import bole_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic [IDX_W-1:0]         index;

  modport source (output valid, kind, value, index, input ready);
  modport sink   (input valid, kind, value, index, output ready);
endinterface

interface bole_rsp_if;
  import bole_pkg::*;

  logic             valid;
  logic             ready;
  logic             done_res;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] count;

  modport source (output valid, done_res, position, count, input ready);
  modport sink   (input valid, done_res, position, count, output ready);
endinterface

FILE: rtl/bole_ram.sv
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bounded_ordered_list_engine_core.sv
// Bounded ordered list of up to CAPACITY signed 32-bit words held in one
// single-port-read RAM. One request is worked at a time; each gives one
// response word. Append goes from accept through ST_RESP to the output
// register. Search and remove walk the stored entries through the RAM read
// port one per cycle (the RAM read is registered, and entries that move down
// are written back one slot lower); ST_RESP waits while an untaken response
// holds the output register. A new request is accepted as soon as the
// previous response sits in the output register.
module bounded_ordered_list_engine_core
  import bole_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic     clk,
  input logic     rst,
  bole_req_if.sink   req,
  bole_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int XW = (PW > IDX_W) ? PW : IDX_W;

  state_t            state;
  logic [PW-1:0]     fill;
  logic [PW-1:0]     ptr;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic [DATA_W-1:0] key;
  kind_t             kind;
  logic              res_done;
  logic [AW-1:0]     res_pos;

  logic              rsp_valid;
  logic              rsp_done;
  logic [POS_W-1:0]  rsp_pos;
  logic [CNT_W-1:0]  rsp_cnt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic accept;
  logic rd_en;
  logic hit;
  logic full;
  logic idx_ok;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (fill == PW'(CAPACITY));
  assign idx_ok    = XW'(req.index) < XW'(fill);
  assign rd_en     = ptr < fill;
  assign hit       = pend && (ram_rdata == key);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    if (accept && (kind_t'(req.kind) == KIND_APPEND) && !full) begin
      ram_we    = 1'b1;
      ram_waddr = fill[AW-1:0];
      ram_wdata = req.value;
    end else if (state == ST_SHIFT && pend) begin
      // move the word read last cycle down one slot
      ram_we = 1'b1;
    end
  end

  bole_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          pend <= 1'b0;
          if (accept) begin
            kind     <= kind_t'(req.kind);
            key      <= req.value;
            res_done <= 1'b0;
            res_pos  <= '0;
            state    <= ST_RESP;
            unique case (kind_t'(req.kind))
              KIND_APPEND: begin
                if (!full) begin
                  res_done <= 1'b1;
                  res_pos  <= fill[AW-1:0];
                  fill     <= fill + PW'(1);
                end
              end
              KIND_SEARCH, KIND_REMOVE_VAL: begin
                ptr <= '0;
                if (fill != '0) begin
                  state <= ST_SCAN;
                end
              end
              KIND_REMOVE_AT: begin
                if (idx_ok) begin
                  res_done <= 1'b1;
                  res_pos  <= AW'(req.index);
                  ptr      <= PW'(req.index) + PW'(1);
                  state    <= ST_SHIFT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          pend      <= rd_en;
          pend_addr <= ptr[AW-1:0];
          if (rd_en) begin
            ptr <= ptr + PW'(1);
          end
          if (hit) begin
            res_done <= 1'b1;
            res_pos  <= pend_addr;
            pend     <= 1'b0;
            if (kind == KIND_REMOVE_VAL) begin
              ptr   <= PW'(pend_addr) + PW'(1);
              state <= ST_SHIFT;
            end else begin
              state <= ST_RESP;
            end
          end else if (!rd_en) begin
            state <= ST_RESP;
          end
        end
        ST_SHIFT: begin
          // read slot ptr now, write it to ptr-1 next cycle
          pend      <= rd_en;
          pend_addr <= AW'(ptr - PW'(1));
          if (rd_en) begin
            ptr <= ptr + PW'(1);
          end else if (!pend) begin
            fill  <= fill - PW'(1);
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && (!rsp_valid || rsp.ready)) begin
      rsp_done <= res_done;
      rsp_pos  <= POS_W'(res_pos);
      rsp_cnt  <= CNT_W'(fill);
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.done_res = rsp_done;
  assign rsp.position = rsp_pos;
  assign rsp.count    = rsp_cnt;

endmodule
